FILE: hw/rtl/pwf_pkg.sv
// ----------------------------------------------------------------------------
// pwf_pkg
// shared types, constants and tables of the plane wave field block
// ----------------------------------------------------------------------------
package pwf_pkg;

    localparam int TRIG_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;

    localparam int POS_W   = 24;
    localparam int FLD_W   = 32;
    localparam int K_W     = 32;
    localparam int PH_W    = 32;
    localparam int DRIVE_W = 16;
    localparam int CFG_AW  = 4;
    localparam int CFG_DW  = 32;
    localparam int CX_W    = 33;
    localparam int CZ_W    = 32;

    localparam logic signed [CX_W-1:0] GAIN_Q30 = 33'sd652032874;

    localparam logic signed [CZ_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    typedef enum logic [CFG_AW-1:0] {
        CFG_K_X      = 4'd0,
        CFG_K_Y      = 4'd1,
        CFG_K_Z      = 4'd2,
        CFG_PHASE    = 4'd3,
        CFG_DRIVE_X  = 4'd4,
        CFG_DRIVE_Y  = 4'd5,
        CFG_DRIVE_Z  = 4'd6,
        CFG_CIRCULAR = 4'd7
    } t_cfg_addr;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    typedef struct packed {
        logic signed [K_W-1:0]     wave_k_x;
        logic signed [K_W-1:0]     wave_k_y;
        logic signed [K_W-1:0]     wave_k_z;
        logic        [PH_W-1:0]    phase_offset;
        logic signed [DRIVE_W-1:0] drive_x;
        logic signed [DRIVE_W-1:0] drive_y;
        logic signed [DRIVE_W-1:0] drive_z;
        logic                      circular_mode;
    } t_cfg;

endpackage

FILE: hw/rtl/pwf_ifs.sv
// ----------------------------------------------------------------------------
// pwf channel interfaces
// point, field and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface pwf_pt_if;
    logic                                valid;
    logic                                ready;
    logic signed [pwf_pkg::POS_W-1:0]    pos_x;
    logic signed [pwf_pkg::POS_W-1:0]    pos_y;
    logic signed [pwf_pkg::POS_W-1:0]    pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface pwf_fld_if;
    logic                                valid;
    logic                                ready;
    logic signed [pwf_pkg::FLD_W-1:0]    field_x;
    logic signed [pwf_pkg::FLD_W-1:0]    field_y;
    logic signed [pwf_pkg::FLD_W-1:0]    field_z;

    modport source (output valid, output field_x, output field_y, output field_z,
                    input ready);
    modport sink   (input valid, input field_x, input field_y, input field_z,
                    output ready);
endinterface

interface pwf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pwf_pkg::CFG_AW-1:0]    addr;
    logic [pwf_pkg::CFG_DW-1:0]    data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: hw/rtl/pwf_phase.sv
// ----------------------------------------------------------------------------
// pwf_phase
// two stage phase unit: k times position products, then sum with offset
// ----------------------------------------------------------------------------
module pwf_phase (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic signed [pwf_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [pwf_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [pwf_pkg::POS_W-1:0]  i_pos_z,
    input  pwf_pkg::t_cfg                     i_cfg,
    output logic                              o_vld,
    output logic [pwf_pkg::PH_W-1:0]          o_phase
);

    localparam int MW = pwf_pkg::K_W + pwf_pkg::POS_W;

    logic signed [MW-1:0]            w_mx;
    logic signed [MW-1:0]            w_my;
    logic signed [MW-1:0]            w_mz;
    logic [pwf_pkg::PH_W-1:0]        r_px;
    logic [pwf_pkg::PH_W-1:0]        r_py;
    logic [pwf_pkg::PH_W-1:0]        r_pz;
    logic [pwf_pkg::PH_W-1:0]        r_phase;
    logic                            r_vld1;
    logic                            r_vld2;

    assign w_mx = i_cfg.wave_k_x * i_pos_x;
    assign w_my = i_cfg.wave_k_y * i_pos_y;
    assign w_mz = i_cfg.wave_k_z * i_pos_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    // products wrap modulo one turn
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px    <= w_mx[pwf_pkg::PH_W-1:0];
            r_py    <= w_my[pwf_pkg::PH_W-1:0];
            r_pz    <= w_mz[pwf_pkg::PH_W-1:0];
            r_phase <= r_px + r_py + r_pz + i_cfg.phase_offset;
        end
    end

    assign o_vld   = r_vld2;
    assign o_phase = r_phase;

endmodule

FILE: hw/rtl/pwf_cordic.sv
// ----------------------------------------------------------------------------
// pwf_cordic
// rotation mode cordic, one register stage per iteration
// ----------------------------------------------------------------------------
module pwf_cordic #(
    parameter int CORDIC_STAGES = pwf_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic [pwf_pkg::PH_W-1:0]          i_phase,
    output logic                              o_vld,
    output logic signed [pwf_pkg::CX_W-1:0]   o_x,
    output logic signed [pwf_pkg::CX_W-1:0]   o_y,
    output pwf_pkg::t_quad                    o_quad
);

    localparam int N = (CORDIC_STAGES < pwf_pkg::ATAN_LEN) ? CORDIC_STAGES
                                                             : pwf_pkg::ATAN_LEN;
    localparam int XW = pwf_pkg::CX_W;
    localparam int ZW = pwf_pkg::CZ_W;

    logic signed [XW-1:0]  a_x [N];
    logic signed [XW-1:0]  a_y [N];
    logic signed [ZW-1:0]  a_z [N];
    pwf_pkg::t_quad        a_q [N];
    logic                  a_v [N];
    logic signed [XW-1:0]  r_x [N];
    logic signed [XW-1:0]  r_y [N];
    logic signed [ZW-1:0]  r_z [N];
    pwf_pkg::t_quad        r_q [N];
    logic                  r_v [N];

    assign a_x[0] = pwf_pkg::GAIN_Q30;
    assign a_y[0] = '0;
    assign a_z[0] = {2'b00, i_phase[pwf_pkg::PH_W-3:0]};
    assign a_q[0] = pwf_pkg::t_quad'(i_phase[pwf_pkg::PH_W-1:pwf_pkg::PH_W-2]);
    assign a_v[0] = i_vld;

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic signed [XW-1:0] w_dx;
        logic signed [XW-1:0] w_dy;

        if (g > 0) begin : g_link
            assign a_x[g] = r_x[g-1];
            assign a_y[g] = r_y[g-1];
            assign a_z[g] = r_z[g-1];
            assign a_q[g] = r_q[g-1];
            assign a_v[g] = r_v[g-1];
        end

        assign w_dx = a_y[g] >>> g;
        assign w_dy = a_x[g] >>> g;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= a_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g] <= a_q[g];
                if (!a_z[g][ZW-1]) begin
                    r_x[g] <= a_x[g] - w_dx;
                    r_y[g] <= a_y[g] + w_dy;
                    r_z[g] <= a_z[g] - pwf_pkg::ATAN_TURNS[g];
                end else begin
                    r_x[g] <= a_x[g] + w_dx;
                    r_y[g] <= a_y[g] - w_dy;
                    r_z[g] <= a_z[g] + pwf_pkg::ATAN_TURNS[g];
                end
            end
        end
    end

    assign o_vld  = r_v[N-1];
    assign o_x    = r_x[N-1];
    assign o_y    = r_y[N-1];
    assign o_quad = r_q[N-1];

endmodule

FILE: hw/rtl/pwf_drive.sv
// ----------------------------------------------------------------------------
// pwf_drive
// quadrant fold and rounding, drive products, saturation to field items
// ----------------------------------------------------------------------------
module pwf_drive #(
    parameter int TRIG_BITS = pwf_pkg::TRIG_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic signed [pwf_pkg::CX_W-1:0]   i_x,
    input  logic signed [pwf_pkg::CX_W-1:0]   i_y,
    input  pwf_pkg::t_quad                    i_quad,
    input  pwf_pkg::t_cfg                     i_cfg,
    output logic                              o_vld,
    output logic signed [pwf_pkg::FLD_W-1:0]  o_field_x,
    output logic signed [pwf_pkg::FLD_W-1:0]  o_field_y,
    output logic signed [pwf_pkg::FLD_W-1:0]  o_field_z
);

    localparam int CW = pwf_pkg::CX_W + 1;
    localparam int SH = 31 - TRIG_BITS;
    localparam int PW = pwf_pkg::DRIVE_W + TRIG_BITS;
    localparam int EW = (PW > pwf_pkg::FLD_W) ? PW : pwf_pkg::FLD_W + 1;
    localparam int FW = pwf_pkg::FLD_W;

    localparam logic signed [CW-1:0] HALF = CW'(64'sd1 <<< (SH - 1));
    localparam logic signed [CW-1:0] LIM  = CW'((64'sd1 <<< (TRIG_BITS - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] FMAX = EW'(64'sd2147483647);
    localparam logic signed [EW-1:0] FMIN = EW'(-64'sd2147483648);

    logic signed [CW-1:0]         w_c;
    logic signed [CW-1:0]         w_s;
    logic signed [CW-1:0]         w_cr;
    logic signed [CW-1:0]         w_sr;
    logic signed [TRIG_BITS-1:0]  w_ct;
    logic signed [TRIG_BITS-1:0]  w_st;
    logic signed [TRIG_BITS-1:0]  r_cos;
    logic signed [TRIG_BITS-1:0]  r_sin;
    logic signed [TRIG_BITS-1:0]  w_ty;
    logic signed [PW-1:0]         r_px;
    logic signed [PW-1:0]         r_py;
    logic signed [PW-1:0]         r_pz;
    logic signed [EW-1:0]         w_ex;
    logic signed [EW-1:0]         w_ey;
    logic signed [EW-1:0]         w_ez;
    logic signed [FW-1:0]         r_fx;
    logic signed [FW-1:0]         r_fy;
    logic signed [FW-1:0]         r_fz;
    logic                         r_vld_a;
    logic                         r_vld_b;
    logic                         r_vld_c;

    function automatic logic signed [TRIG_BITS-1:0] clamp_trig(
        input logic signed [CW-1:0] v
    );
        logic signed [CW-1:0] t;
        t = v;
        if (t > LIM) begin
            t = LIM;
        end else if (t < -LIM) begin
            t = -LIM;
        end
        return t[TRIG_BITS-1:0];
    endfunction

    function automatic logic signed [FW-1:0] sat_field(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] t;
        t = v;
        if (t > FMAX) begin
            t = FMAX;
        end else if (t < FMIN) begin
            t = FMIN;
        end
        return t[FW-1:0];
    endfunction

    always_comb begin
        case (i_quad)
            pwf_pkg::QUAD_0: begin
                w_c = CW'(i_x);
                w_s = CW'(i_y);
            end
            pwf_pkg::QUAD_1: begin
                w_c = -CW'(i_y);
                w_s = CW'(i_x);
            end
            pwf_pkg::QUAD_2: begin
                w_c = -CW'(i_x);
                w_s = -CW'(i_y);
            end
            pwf_pkg::QUAD_3: begin
                w_c = CW'(i_y);
                w_s = -CW'(i_x);
            end
            default: begin
                w_c = CW'(i_x);
                w_s = CW'(i_y);
            end
        endcase
    end

    // round half up, then floor shift to trig precision
    assign w_cr = (w_c + HALF) >>> SH;
    assign w_sr = (w_s + HALF) >>> SH;
    assign w_ct = clamp_trig(w_cr);
    assign w_st = clamp_trig(w_sr);

    assign w_ty = i_cfg.circular_mode ? r_sin : r_cos;

    assign w_ex = EW'(r_px);
    assign w_ey = EW'(r_py);
    assign w_ez = EW'(r_pz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= w_ct;
            r_sin <= w_st;
            r_px  <= i_cfg.drive_x * r_cos;
            r_py  <= i_cfg.drive_y * w_ty;
            r_pz  <= i_cfg.drive_z * r_cos;
            r_fx  <= sat_field(w_ex);
            r_fy  <= sat_field(w_ey);
            r_fz  <= i_cfg.circular_mode ? '0 : sat_field(w_ez);
        end
    end

    assign o_vld     = r_vld_c;
    assign o_field_x = r_fx;
    assign o_field_y = r_fy;
    assign o_field_z = r_fz;

endmodule

FILE: hw/rtl/plane_wave_field_at_point_top.sv
// ----------------------------------------------------------------------------
// plane_wave_field_at_point_top
// incident plane wave electric field at one grid point per item
// pipeline from acceptance to a valid result: 2 phase stages, the cordic stages
//   (16 at the default) and 3 output stages
// throughput: one item per cycle, a result held at the output stalls every stage
// reset: synchronous active low, clears the settings and all stage valid bits
// ----------------------------------------------------------------------------
module plane_wave_field_at_point_top #(
    parameter int TRIG_BITS     = pwf_pkg::TRIG_BITS_DEF,
    parameter int CORDIC_STAGES = pwf_pkg::CORDIC_STAGES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pwf_pt_if.sink       i_pt,
    pwf_fld_if.source    o_fld,
    pwf_cfg_if.sink      i_cfg
);

    pwf_pkg::t_cfg                       r_cfg;
    logic                                w_en;
    logic                                w_ph_vld;
    logic [pwf_pkg::PH_W-1:0]            w_phase;
    logic                                w_cd_vld;
    logic signed [pwf_pkg::CX_W-1:0]     w_cx;
    logic signed [pwf_pkg::CX_W-1:0]     w_cy;
    pwf_pkg::t_quad                      w_quad;
    logic                                w_out_vld;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (pwf_pkg::t_cfg_addr'(i_cfg.addr))
                pwf_pkg::CFG_K_X:      r_cfg.wave_k_x      <= i_cfg.data;
                pwf_pkg::CFG_K_Y:      r_cfg.wave_k_y      <= i_cfg.data;
                pwf_pkg::CFG_K_Z:      r_cfg.wave_k_z      <= i_cfg.data;
                pwf_pkg::CFG_PHASE:    r_cfg.phase_offset  <= i_cfg.data;
                pwf_pkg::CFG_DRIVE_X:  r_cfg.drive_x       <= i_cfg.data[pwf_pkg::DRIVE_W-1:0];
                pwf_pkg::CFG_DRIVE_Y:  r_cfg.drive_y       <= i_cfg.data[pwf_pkg::DRIVE_W-1:0];
                pwf_pkg::CFG_DRIVE_Z:  r_cfg.drive_z       <= i_cfg.data[pwf_pkg::DRIVE_W-1:0];
                pwf_pkg::CFG_CIRCULAR: r_cfg.circular_mode <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    // whole pipeline advances unless a finished item is held at the output
    assign w_en       = o_fld.ready || !w_out_vld;
    assign i_pt.ready = w_en;

    pwf_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_pt.valid),
        .i_pos_x (i_pt.pos_x),
        .i_pos_y (i_pt.pos_y),
        .i_pos_z (i_pt.pos_z),
        .i_cfg   (r_cfg),
        .o_vld   (w_ph_vld),
        .o_phase (w_phase)
    );

    pwf_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_ph_vld),
        .i_phase (w_phase),
        .o_vld   (w_cd_vld),
        .o_x     (w_cx),
        .o_y     (w_cy),
        .o_quad  (w_quad)
    );

    pwf_drive #(
        .TRIG_BITS (TRIG_BITS)
    ) u_drive (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_vld     (w_cd_vld),
        .i_x       (w_cx),
        .i_y       (w_cy),
        .i_quad    (w_quad),
        .i_cfg     (r_cfg),
        .o_vld     (w_out_vld),
        .o_field_x (o_fld.field_x),
        .o_field_y (o_fld.field_y),
        .o_field_z (o_fld.field_z)
    );

    assign o_fld.valid = w_out_vld;

    a_out_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_fld.valid)
        else $error("result valid right after reset");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fld.valid && !o_fld.ready |-> !i_pt.ready)
        else $error("point taken while a result is stalled");

    a_stall_freezes_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pt.ready |=> o_fld.valid && $stable(o_fld.field_x)
                        && $stable(o_fld.field_y) && $stable(o_fld.field_z))
        else $error("output changed while the pipeline was stalled");

endmodule
